// ===== hw/rtl/rec_pkg.sv =====
// Shared types and constants for the carry-propagating range encoder.
// Used by rec_ctrl, rec_dp and range_encoder_with_carry.
package rec_pkg;

  localparam int LOW_W      = 33;
  localparam int RANGE_W    = 32;
  localparam int BYTE_W     = 8;
  localparam int REP_W      = 32;
  localparam int START_W    = 16;
  localparam int FREQ_W     = 17;
  localparam int CNT_W      = 5;

  localparam logic [CNT_W-1:0] DIV_LAST_STEP = CNT_W'(RANGE_W - 1);
  localparam logic [CNT_W-1:0] FLUSH_SHIFTS  = CNT_W'(5);

  localparam logic [RANGE_W-1:0] ALL_ONES32 = 32'hFFFF_FFFF;
  localparam logic [BYTE_W-1:0]  FF_BYTE    = 8'hFF;

  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  typedef struct packed {
    logic load_in;
    logic div_init;
    logic div_step;
    logic mul;
    logic upd;
    logic shift;
    logic rng_shift;
    logic push2;
    logic flush;
  } rec_cmd_t;

  typedef struct packed {
    logic norm_done;
    logic emit;
    logic pend_gt1;
    logic can_push;
    logic hold_v;
    logic out_free;
  } rec_sts_t;

endpackage

// ===== hw/rtl/rec_ctrl.sv =====
// Sequencer of the range encoder: divide, multiply, update, shift loop, flush.
// Depends on rec_pkg; drives rec_dp through rec_cmd_t, reads rec_sts_t.
module rec_ctrl
  import rec_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_req_type,
  input  rec_sts_t sts,
  output rec_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;
  localparam logic [2:0] S_PUSH2 = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             fin_r, fin_nxt;
  logic             done;

  assign in_ready = (state_r == S_IDLE);
  assign done     = fin_r ? (cnt_r == '0) : sts.norm_done;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    fin_nxt   = fin_r;
    cmd       = '0;
    cmd.rng_shift = !fin_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          fin_nxt     = (in_req_type == REQ_FINISH);
          if (in_req_type == REQ_FINISH) begin
            cnt_nxt   = FLUSH_SHIFTS;
            state_nxt = S_CHK;
          end else begin
            cnt_nxt   = DIV_LAST_STEP;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (done) begin
          state_nxt = S_FIN;
        end else if (!sts.emit || sts.can_push) begin
          cmd.shift = 1'b1;
          if (fin_r) begin
            cnt_nxt = cnt_r - 1'b1;
          end
          if (sts.emit && sts.pend_gt1) begin
            state_nxt = S_PUSH2;
          end
        end
      end
      S_PUSH2: begin
        if (sts.can_push) begin
          cmd.push2 = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_FIN: begin
        if (!sts.hold_v) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    cmd.div_init = cmd.load_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

// ===== hw/rtl/rec_dp.sv =====
// Datapath of the range encoder: coder state, radix-2 divider, multipliers,
// byte shifter, one-deep hold stage and output register. Depends on rec_pkg.
module rec_dp
  import rec_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  rec_cmd_t           cmd,
  output rec_sts_t           sts,
  input  logic [START_W-1:0] in_sym_start,
  input  logic [FREQ_W-1:0]  in_sym_size,
  input  logic [FREQ_W-1:0]  in_freq_total,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BYTE_W-1:0]  out_byte,
  output logic [REP_W-1:0]   out_repeat,
  output logic               out_last_flag
);

  // coder state
  logic [LOW_W-1:0]   low_r, low_nxt;
  logic [RANGE_W-1:0] range_r, range_nxt;
  logic [BYTE_W-1:0]  cache_r, cache_nxt;
  logic [REP_W-1:0]   pend_r, pend_nxt;

  // operands and divider
  logic [START_W-1:0] start_r;
  logic [FREQ_W-1:0]  size_r, div_d_r;
  logic [FREQ_W-1:0]  rem_r;
  logic [RANGE_W-1:0] quo_r;
  logic [FREQ_W:0]    trial;
  logic               ge;

  // products
  logic [RANGE_W-1:0] prod_sq;
  logic [48:0]        prod_rq;
  logic [RANGE_W-1:0] psq_r;
  logic [48:0]        prq_r;
  logic [RANGE_W-1:0] rng_sat;

  // shift step
  logic [RANGE_W-1:0] lo32;
  logic               carry;
  logic               emit;
  logic [BYTE_W-1:0]  sec_byte_r;
  logic [REP_W-1:0]   sec_rep_r;

  // result staging
  logic               push;
  logic [BYTE_W-1:0]  new_byte;
  logic [REP_W-1:0]   new_rep;
  logic               hold_v_r;
  logic [BYTE_W-1:0]  hold_byte_r;
  logic [REP_W-1:0]   hold_rep_r;
  logic               out_v_r;
  logic [BYTE_W-1:0]  out_byte_r;
  logic [REP_W-1:0]   out_rep_r;
  logic               out_last_r;

  assign trial   = {rem_r, quo_r[RANGE_W-1]};
  assign ge      = (trial >= {1'b0, div_d_r});
  assign prod_sq = RANGE_W'(start_r) * quo_r;
  assign prod_rq = 49'(size_r) * 49'(quo_r);
  assign rng_sat = (prq_r[48:RANGE_W] != '0) ? ALL_ONES32 : prq_r[RANGE_W-1:0];

  assign lo32  = low_r[RANGE_W-1:0];
  assign carry = low_r[LOW_W-1];
  assign emit  = (lo32[31:24] != FF_BYTE) || carry;

  assign push     = (cmd.shift && emit) || cmd.push2;
  assign new_byte = cmd.push2 ? sec_byte_r : (cache_r + BYTE_W'(carry));
  assign new_rep  = cmd.push2 ? sec_rep_r : REP_W'(1);

  assign sts.norm_done = (range_r[31:24] != '0);
  assign sts.emit      = emit;
  assign sts.pend_gt1  = (pend_r > REP_W'(1));
  assign sts.can_push  = !hold_v_r || !out_v_r;
  assign sts.hold_v    = hold_v_r;
  assign sts.out_free  = !out_v_r;

  assign out_valid     = out_v_r;
  assign out_byte      = out_byte_r;
  assign out_repeat    = out_rep_r;
  assign out_last_flag = out_last_r;

  always_comb begin
    low_nxt   = low_r;
    range_nxt = range_r;
    cache_nxt = cache_r;
    pend_nxt  = pend_r;
    if (cmd.upd) begin
      low_nxt   = low_r + {1'b0, psq_r};
      range_nxt = (rng_sat == '0) ? RANGE_W'(1) : rng_sat;
    end
    if (cmd.shift) begin
      if (emit) begin
        cache_nxt = lo32[31:24];
        pend_nxt  = REP_W'(1);
      end else if (pend_r != ALL_ONES32) begin
        pend_nxt  = pend_r + 1'b1;
      end
      low_nxt = {1'b0, lo32[23:0], 8'h00};
      if (cmd.rng_shift) begin
        range_nxt = {range_r[23:0], 8'h00};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r   <= '0;
      range_r <= ALL_ONES32;
      cache_r <= '0;
      pend_r  <= REP_W'(1);
    end else begin
      low_r   <= low_nxt;
      range_r <= range_nxt;
      cache_r <= cache_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      start_r <= in_sym_start;
      size_r  <= (in_sym_size == '0) ? FREQ_W'(1) : in_sym_size;
      div_d_r <= (in_freq_total == '0) ? FREQ_W'(1) : in_freq_total;
    end
    if (cmd.div_init) begin
      rem_r <= '0;
      quo_r <= range_r;
    end else if (cmd.div_step) begin
      rem_r <= ge ? FREQ_W'(trial - {1'b0, div_d_r}) : trial[FREQ_W-1:0];
      quo_r <= {quo_r[RANGE_W-2:0], ge};
    end
    if (cmd.mul) begin
      psq_r <= prod_sq;
      prq_r <= prod_rq;
    end
    if (cmd.shift && emit) begin
      sec_byte_r <= FF_BYTE + BYTE_W'(carry);
      sec_rep_r  <= pend_r - 1'b1;
    end
    if (push) begin
      hold_byte_r <= new_byte;
      hold_rep_r  <= new_rep;
    end
  end

  // a held result moves out once the next one arrives (not last) or at item end (last)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (out_v_r && out_ready) begin
        out_v_r <= 1'b0;
      end
      if (push) begin
        hold_v_r <= 1'b1;
        if (hold_v_r) begin
          out_v_r <= 1'b1;
        end
      end else if (cmd.flush) begin
        hold_v_r <= 1'b0;
        out_v_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((push && hold_v_r) || cmd.flush) begin
      out_byte_r <= hold_byte_r;
      out_rep_r  <= hold_rep_r;
      out_last_r <= cmd.flush;
    end
  end

endmodule

// ===== hw/rtl/range_encoder_with_carry.sv =====
// Carry-propagating range encoder (LZMA style), top level.
// Instantiates rec_ctrl and rec_dp; depends on rec_pkg.
//
// An encode item: the 32-bit by 17-bit quotient comes from a radix-2 divider at
// one bit per cycle, followed by a multiply step, an update step and the
// renormalization loop of at most three byte shifts; a shift that emits while
// more than one byte is pending adds a second push step. A finish item runs
// its five shifts. One item is in work at a time. Results leave through a
// one-deep hold stage and an output register, so the last result of an item
// appears only once the item is done; a stalled output delays the shift loop
// only when both are full.
module range_encoder_with_carry
  import rec_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic [START_W-1:0] in_sym_start,
  input  logic [FREQ_W-1:0]  in_sym_size,
  input  logic [FREQ_W-1:0]  in_freq_total,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BYTE_W-1:0]  out_byte,
  output logic [REP_W-1:0]   out_repeat,
  output logic               out_last_flag
);

  rec_cmd_t cmd;
  rec_sts_t sts;

  rec_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .sts         (sts),
    .cmd         (cmd)
  );

  rec_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_sym_start  (in_sym_start),
    .in_sym_size   (in_sym_size),
    .in_freq_total (in_freq_total),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_repeat    (out_repeat),
    .out_last_flag (out_last_flag)
  );

endmodule

// ===== tb/sv/tb_range_encoder_with_carry.sv =====
// Self-checking testbench for range_encoder_with_carry: directed and random symbol and
// flush requests, each checked against a cycle-free predictor of the carry range coder.
// Depends on rec_pkg and the range_encoder_with_carry RTL.
module tb_range_encoder_with_carry;
  import rec_pkg::*;

  localparam logic [RANGE_W-1:0] CARRY_LIMIT = 32'hFF00_0000;
  localparam logic [RANGE_W-1:0] TOP_VALUE   = 32'h0100_0000;
  localparam int N_RANDOM     = 87;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [BYTE_W-1:0] out_b;
    logic [REP_W-1:0]  rep_cnt;
    logic              last_f;
  } enc_out_t;

  class rec_scoreboard;
    logic [LOW_W-1:0]   low_acc;
    logic [RANGE_W-1:0] rng;
    logic [BYTE_W-1:0]  cache;
    logic [REP_W-1:0]   pend;
    enc_out_t           due_q[$];
    int                 errors;

    function new();
      low_acc = '0;
      rng     = ALL_ONES32;
      cache   = '0;
      pend    = 1;
      errors  = 0;
    endfunction

    function void shift_byte();
      logic               carry;
      logic [RANGE_W-1:0] lo32;
      carry = low_acc[32];
      lo32  = low_acc[31:0];
      if (lo32 < CARRY_LIMIT || carry) begin
        due_q.push_back('{out_b: cache + BYTE_W'(carry), rep_cnt: 1, last_f: 1'b0});
        if (pend > 1)
          due_q.push_back('{out_b: FF_BYTE + BYTE_W'(carry), rep_cnt: pend - 1, last_f: 1'b0});
        cache = lo32[31:24];
        pend  = 1;
      end else if (pend != ALL_ONES32) begin
        pend = pend + 1;
      end
      low_acc = {1'b0, lo32[23:0], 8'h00};
    endfunction

    function void note_input(logic req, logic [START_W-1:0] start,
                             logic [FREQ_W-1:0] size, logic [FREQ_W-1:0] total);
      int                 n0;
      logic [RANGE_W-1:0] q;
      logic [RANGE_W-1:0] sq;
      logic [63:0]        prod;
      logic [FREQ_W-1:0]  t;
      logic [FREQ_W-1:0]  s;
      n0 = due_q.size();
      if (req == REQ_FINISH) begin
        for (int i = 0; i < FLUSH_SHIFTS; i++)
          shift_byte();
      end else begin
        t = (total == 0) ? FREQ_W'(1) : total;
        s = (size == 0) ? FREQ_W'(1) : size;
        q = rng / RANGE_W'(t);
        sq = RANGE_W'(start) * q;
        low_acc = low_acc + {1'b0, sq};
        prod = 64'(s) * 64'(q);
        rng = (prod > 64'(ALL_ONES32)) ? ALL_ONES32 : prod[31:0];
        if (rng == 0)
          rng = 1;
        while (rng < TOP_VALUE) begin
          rng = rng << 8;
          shift_byte();
        end
      end
      if (due_q.size() > n0)
        due_q[due_q.size()-1].last_f = 1'b1;
    endfunction

    function void check_result(enc_out_t got);
      enc_out_t want;
      if (due_q.size() == 0) begin
        $error("unexpected transfer: out_byte %0h out_repeat %0d out_last_flag %0b",
               got.out_b, got.rep_cnt, got.last_f);
        errors++;
        return;
      end
      want = due_q.pop_front();
      if (got.out_b !== want.out_b) begin
        $error("out_byte: expected %0h, got %0h", want.out_b, got.out_b);
        errors++;
      end
      if (got.rep_cnt !== want.rep_cnt) begin
        $error("out_repeat: expected %0d, got %0d", want.rep_cnt, got.rep_cnt);
        errors++;
      end
      if (got.last_f !== want.last_f) begin
        $error("out_last_flag: expected %0b, got %0b", want.last_f, got.last_f);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_req_type;
  logic [START_W-1:0] in_sym_start;
  logic [FREQ_W-1:0]  in_sym_size;
  logic [FREQ_W-1:0]  in_freq_total;
  logic               out_valid;
  logic               out_ready;
  logic [BYTE_W-1:0]  out_byte;
  logic [REP_W-1:0]   out_repeat;
  logic               out_last_flag;

  rec_scoreboard sb;
  bit            in_burst;
  bit            out_burst;

  range_encoder_with_carry i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_sym_start  (in_sym_start),
    .in_sym_size   (in_sym_size),
    .in_freq_total (in_freq_total),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_repeat    (out_repeat),
    .out_last_flag (out_last_flag)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("tb_range_encoder_with_carry NOT OK");
    $finish;
  end

  task automatic drive_req(input logic req, input logic [START_W-1:0] start,
                           input logic [FREQ_W-1:0] size, input logic [FREQ_W-1:0] total);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_sym_start  <= start;
    in_sym_size   <= size;
    in_freq_total <= total;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_input(req, start, size, total);
    if ($urandom_range(0, 15) == 0)
      in_burst = !in_burst;
  endtask

  // result side: random back-pressure, one check per transfer
  initial begin
    enc_out_t got;
    int       stall;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got = '{out_b: out_byte, rep_cnt: out_repeat, last_f: out_last_flag};
      sb.check_result(got);
      if ($urandom_range(0, 15) == 0)
        out_burst = !out_burst;
    end
  end

  initial begin
    int                 kind;
    int                 cap;
    logic [FREQ_W-1:0]  t;
    logic [FREQ_W-1:0]  s;
    logic [START_W-1:0] st;
    sb = new();
    in_burst  = 1'b0;
    out_burst = 1'b0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_req_type   <= REQ_ENCODE;
    in_sym_start  <= '0;
    in_sym_size   <= '0;
    in_freq_total <= '0;
    out_ready     <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // flush from reset state, field extremes, zero/oversized frequencies, wrapped start
    drive_req(REQ_FINISH, 16'hFFFF, 17'h1FFFF, 17'h1FFFF);
    drive_req(REQ_ENCODE, 16'd0, 17'd1, 17'd65536);
    drive_req(REQ_ENCODE, 16'd65535, 17'd1, 17'd65536);
    drive_req(REQ_ENCODE, 16'd0, 17'd65536, 17'd65536);
    drive_req(REQ_ENCODE, 16'd0, 17'd0, 17'd0);
    drive_req(REQ_ENCODE, 16'd0, 17'h1FFFF, 17'd1);
    drive_req(REQ_ENCODE, 16'd65535, 17'd1, 17'd1);
    drive_req(REQ_ENCODE, 16'hAAAA, 17'h15555, 17'h1FFFF);
    drive_req(REQ_ENCODE, 16'h5555, 17'h0AAAA, 17'h10000);
    // top symbol repeatedly to build a run of 0xFF bytes, then a carry
    for (int i = 0; i < 8; i++)
      drive_req(REQ_ENCODE, 16'd255, 17'd1, 17'd256);
    drive_req(REQ_ENCODE, 16'd0, 17'd1, 17'd256);
    drive_req(REQ_FINISH, 16'd0, 17'd0, 17'd0);
    drive_req(REQ_FINISH, 16'd0, 17'd0, 17'd0);
    drive_req(REQ_ENCODE, 16'd1, 17'd1, 17'd2);
    drive_req(REQ_ENCODE, 16'd0, 17'd1, 17'd2);

    for (int n = 0; n < N_RANDOM; n++) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        drive_req(REQ_FINISH, START_W'($urandom), FREQ_W'($urandom), FREQ_W'($urandom));
      end else if (kind < 15) begin
        drive_req(REQ_ENCODE, START_W'($urandom), FREQ_W'($urandom), FREQ_W'($urandom));
      end else begin
        case ($urandom_range(0, 3))
          0: cap = 16;
          1: cap = 256;
          2: cap = 4096;
          default: cap = 65536;
        endcase
        t = FREQ_W'($urandom_range(1, cap));
        s = FREQ_W'($urandom_range(1, int'(t)));
        if (kind < 40)
          st = START_W'(t - s);
        else if (kind < 50)
          st = '0;
        else
          st = START_W'($urandom_range(0, int'(t - s)));
        drive_req(REQ_ENCODE, st, s, t);
      end
    end
    drive_req(REQ_FINISH, 16'd0, 17'd0, 17'd0);
    in_valid <= 1'b0;

    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.due_q.size() == 0)
      $display("tb_range_encoder_with_carry OK");
    else
      $display("tb_range_encoder_with_carry NOT OK");
    $finish;
  end

endmodule
